/* rtl/soundex_encoder_macros.svh */
// Assertion macros shared by the Soundex encoder RTL.
`ifndef SOUNDEX_ENCODER_MACROS_SVH
`define SOUNDEX_ENCODER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SDX_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("soundex assertion failed");

// Antecedent implies consequent in the next cycle.
`define SDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("soundex assertion failed");

`endif

/* rtl/sdx_pkg.sv */
// Package with types, constants and lookup functions of the Soundex encoder.
package sdx_pkg;

    localparam int CODE_BYTES = 8;
    localparam int VALUE_W    = 30;

    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_Z     = 8'h5A;
    localparam logic [7:0] ASCII_LOW_A = 8'h61;
    localparam logic [7:0] ASCII_LOW_Z = 8'h7A;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [3:0] DIGIT_SKIP  = 4'd9;
    localparam logic [2:0] DIGIT_NONE  = 3'd7;

    localparam logic [4:0] MULT_FIRST  = 5'd26;
    localparam logic [4:0] MULT_DIGIT  = 5'd7;
    localparam logic [4:0] MULT_LENGTH = 5'd9;

    localparam logic [3:0] CODE_LENGTH_RESET = 4'd4;

    localparam logic [3:0] SCORE_TABLE [26] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, DIGIT_SKIP, 4'd0, 4'd2,
        4'd2, 4'd4, 4'd5, 4'd5, 4'd0, 4'd1, 4'd2, 4'd6, 4'd2, 4'd3,
        4'd0, 4'd1, DIGIT_SKIP, 4'd2, DIGIT_SKIP, 4'd2
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PACK,
        ST_FINAL
    } sdx_state_t;

    typedef logic [CODE_BYTES-1:0][7:0] code_bytes_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= ASCII_LOW_A && c <= ASCII_LOW_Z)
        begin
            u = c - CASE_OFFSET;
        end
        return u;
    endfunction

    function automatic logic [3:0] score(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] idx;
        logic [3:0] s;
        u   = upcase(c);
        idx = u - ASCII_A;
        s   = 4'd0;
        if (u >= ASCII_A && u <= ASCII_Z)
        begin
            s = SCORE_TABLE[idx[4:0]];
        end
        return s;
    endfunction

endpackage

/* rtl/soundex_encoder.sv */
// Soundex encoder: streams name bytes in, emits the padded code and its packed value.
//
// Input channel s_*: one name byte per beat in s_tdata, s_tlast on the final byte.
// Output channel m_*: one beat per name, carrying the code characters and the
// packed integer value in m_tdata and the leading-letter flag in m_tuser.
// Configuration: cfg_we writes cfg_data into the code length register
// (reset 4); 0 acts as 1 and values above MAX_CODE_LENGTH act as the maximum.
// Throughput: bytes without s_tlast are taken one per cycle while the block is
// idle. After a final byte the input is not ready while one shared multiply-add
// unit folds the code into its packed value one character per cycle in ST_PACK
// (times 26, times 7, then times 9 plus length in ST_FINAL), and until ST_FINAL
// has loaded the result into the output register.
// The result sits in an output register, so a new name can start while it
// waits; if the receiver stalls with a result still pending when the next one
// is ready, the block holds the new result and keeps s_tready low.
// Reset clears the partial code and the output valid and returns the length
// register to 4.
module soundex_encoder #(
    parameter int MAX_CODE_LENGTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,       // code_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // name_char
    input  logic        s_tlast,        // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,        // code_chars[63:0], code_value[93:64], zero fill
    output logic        m_tuser         // leading_is_letter
);
    import sdx_pkg::*;

    localparam logic [3:0] MAX_LEN = 4'(MAX_CODE_LENGTH);

    sdx_state_t  state_reg, state_next;
    logic [3:0]  code_length_reg;
    logic        in_name_reg, in_name_next;
    code_bytes_t store_reg, store_next;
    logic [3:0]  kept_reg, kept_next;
    logic [2:0]  prev_reg, prev_next;

    code_bytes_t work_reg, work_next;
    logic [3:0]  len_reg, len_next;
    logic [2:0]  step_reg, step_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic        letter_reg, letter_next;

    logic        m_valid_reg, m_valid_next;
    code_bytes_t out_chars_reg, out_chars_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic        out_letter_reg, out_letter_next;

    logic [3:0]  len_eff;
    logic        in_accept;
    logic        out_load;

    // Character update results.
    code_bytes_t store_upd;
    logic [3:0]  kept_upd;
    logic [2:0]  prev_upd;
    code_bytes_t padded;
    logic [7:0]  up_char;
    logic [3:0]  char_score;
    logic [7:0]  lead_off;

    // Shared multiply-add unit.
    logic [4:0]  unit_mult;
    logic [3:0]  unit_add;
    logic [VALUE_W+4:0] unit_prod;
    logic [VALUE_W-1:0] unit_out;
    logic [7:0]  digit_byte;

    always_comb
    begin
        if (code_length_reg == 4'd0)
        begin
            len_eff = 4'd1;
        end
        else if (code_length_reg > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = code_length_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Per-character update of the code being built.
    always_comb
    begin
        up_char    = upcase(s_tdata);
        char_score = score(s_tdata);
        store_upd  = store_reg;
        kept_upd   = kept_reg;
        prev_upd   = prev_reg;
        if (!in_name_reg)
        begin
            store_upd    = '0;
            store_upd[0] = up_char;
            kept_upd     = 4'd1;
            prev_upd     = DIGIT_NONE;
        end
        else if (kept_reg < len_eff)
        begin
            if (char_score != 4'd0 && char_score != DIGIT_SKIP &&
                char_score[2:0] != prev_reg)
            begin
                store_upd[kept_reg[2:0]] = ASCII_ZERO + {4'd0, char_score};
                kept_upd = kept_reg + 4'd1;
            end
            if (char_score != DIGIT_SKIP)
            begin
                prev_upd = char_score[2:0];
            end
        end
    end

    // Cut to the length in force (zero bytes beyond it), then pad the unfilled positions within it with '0'.
    always_comb
    begin
        for (int k = 0; k < CODE_BYTES; k++)
        begin
            if (4'(k) >= len_eff)
            begin
                padded[k] = 8'h00;
            end
            else if (4'(k) < kept_upd)
            begin
                padded[k] = store_upd[k];
            end
            else
            begin
                padded[k] = ASCII_ZERO;
            end
        end
        lead_off = padded[0] - ASCII_A;
    end

    // The digit character low bits give the digit value directly.
    always_comb
    begin
        digit_byte = work_reg[step_reg];
        if (state_reg == ST_FINAL)
        begin
            unit_mult = MULT_LENGTH;
            unit_add  = len_reg;
        end
        else
        begin
            unit_mult = (step_reg == 3'd1) ? MULT_FIRST : MULT_DIGIT;
            unit_add  = {1'b0, digit_byte[2:0]};
        end
        unit_prod = acc_reg * unit_mult;
        unit_out  = unit_prod[VALUE_W-1:0] + VALUE_W'(unit_add);
    end

    assign out_load = (state_reg == ST_FINAL) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        in_name_next    = in_name_reg;
        store_next      = store_reg;
        kept_next       = kept_reg;
        prev_next       = prev_reg;
        work_next       = work_reg;
        len_next        = len_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        letter_next     = letter_reg;
        out_chars_next  = out_chars_reg;
        out_value_next  = out_value_reg;
        out_letter_next = out_letter_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tlast)
                    begin
                        work_next    = padded;
                        len_next     = len_eff;
                        acc_next     = VALUE_W'(lead_off[4:0]);
                        letter_next  = (padded[0] >= ASCII_A) && (padded[0] <= ASCII_Z);
                        step_next    = 3'd1;
                        state_next   = (len_eff > 4'd1) ? ST_PACK : ST_FINAL;
                        in_name_next = 1'b0;
                        store_next   = '0;
                        kept_next    = 4'd0;
                        prev_next    = DIGIT_NONE;
                    end
                    else
                    begin
                        in_name_next = 1'b1;
                        store_next   = store_upd;
                        kept_next    = kept_upd;
                        prev_next    = prev_upd;
                    end
                end
            end
            ST_PACK:
            begin
                acc_next  = unit_out;
                step_next = step_reg + 3'd1;
                if ({1'b0, step_reg} == len_reg - 4'd1)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_load)
                begin
                    out_chars_next  = work_reg;
                    out_value_next  = letter_reg ? unit_out : '0;
                    out_letter_next = letter_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            code_length_reg <= CODE_LENGTH_RESET;
            in_name_reg     <= 1'b0;
            store_reg       <= '0;
            kept_reg        <= 4'd0;
            prev_reg        <= DIGIT_NONE;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_name_reg <= in_name_next;
            store_reg   <= store_next;
            kept_reg    <= kept_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                code_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        len_reg        <= len_next;
        step_reg       <= step_next;
        acc_reg        <= acc_next;
        letter_reg     <= letter_next;
        out_chars_reg  <= out_chars_next;
        out_value_reg  <= out_value_next;
        out_letter_reg <= out_letter_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_chars_reg};
    assign m_tuser  = out_letter_reg;

`include "soundex_encoder_macros.svh"

    `SDX_ASSERT_NEXT(a_last_blocks_input, in_accept && s_tlast, !s_tready)
    `SDX_ASSERT_IMPL(a_kept_bounded, 1'b1, kept_reg <= MAX_LEN)
    `SDX_ASSERT_IMPL(a_nonletter_zero, m_tvalid && !m_tuser, m_tdata[93:64] == '0)
    `SDX_ASSERT_IMPL(a_load_when_free, out_load, !m_valid_reg || m_tready)

endmodule
